// ===== sv/sid_pkg.sv =====
// Package for the segment intersection pipeline: default widths, register reset,
// and the lexicographic compare and Q.16 saturation helpers.
// No dependencies.
`default_nettype none

package sid_pkg;

  localparam int CoordBitsDef = 16;
  localparam int FracBitsDef  = 16;
  localparam int ThrW         = 16;
  localparam logic [ThrW-1:0] ThrReset = 16'd1;
  localparam int PointW       = 32;
  localparam int WideW        = 64;
  localparam int ClampExp     = 62;

  localparam logic signed [WideW-1:0] PtMax = 64'sd2147483647;
  localparam logic signed [WideW-1:0] PtMin = -64'sd2147483648;

  // u < v, x first and then y
  function automatic logic lex_lt(input logic signed [WideW-1:0] ux,
                                  input logic signed [WideW-1:0] uy,
                                  input logic signed [WideW-1:0] vx,
                                  input logic signed [WideW-1:0] vy);
    return (ux < vx) || ((ux == vx) && (uy < vy));
  endfunction

  function automatic logic [PointW-1:0] sat_pt(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] r;
    r = v;
    if (v > PtMax) r = PtMax;
    if (v < PtMin) r = PtMin;
    return r[PointW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/segment_intersection_2d.sv =====
// Top level of the 2D segment intersection pipeline: threshold register,
// stall control, front stages, divider and back stages.
// Depends on sid_pkg, sid_front, sid_div, sid_back.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  a, b, c, d coordinates
//   m_axis    out  m_axis_tvalid/m_axis_tready  hit, overlap flag, Q.FRAC point
//   cfg       in   cfg_we_i                     parallel threshold
//
// One request per cycle sustained while the stages advance; the divider resolves one
// quotient bit per stage.
// All stages advance together whenever the output register is empty or taken.
// Reset clears valid bits and loads the threshold with 1.
`default_nettype none

module segment_intersection_2d import sid_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
  input  wire logic [((8*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // point_x, point_y
  output logic [2*PointW-1:0]                        m_axis_tdata,
  // hit, collinear_overlap
  output logic [1:0]                                 m_axis_tuser,
  input  wire logic                                  cfg_we_i,
  input  wire logic [ThrW-1:0]                       cfg_wdata_i
);

  localparam int C  = COORD_BITS;
  localparam int MW = 2*C + 1;
  localparam int QW = 3*C + 1 + FRAC_BITS;
  localparam int SW = 12*C + 4;

  logic [ThrW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic          fv, dv;
  logic [QW-1:0] ux, uy, qx, qy;
  logic [MW-1:0] ud;
  logic [SW-1:0] fside, dside;
  logic          hit, col;
  logic [PointW-1:0] px, py;

  sid_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata[8*C-1:0]),
    .thr_i   (thr_q),
    .valid_o (fv),
    .ux_o    (ux),
    .uy_o    (uy),
    .ud_o    (ud),
    .side_o  (fside)
  );

  sid_div #(.QW(QW), .DW(MW), .SW(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv),
    .nx_i    (ux),
    .ny_i    (uy),
    .d_i     (ud),
    .side_i  (fside),
    .valid_o (dv),
    .qx_o    (qx),
    .qy_o    (qy),
    .side_o  (dside)
  );

  sid_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .qx_i    (qx),
    .qy_i    (qy),
    .side_i  (dside),
    .valid_o (m_axis_tvalid),
    .hit_o   (hit),
    .col_o   (col),
    .px_o    (px),
    .py_o    (py)
  );

  assign m_axis_tdata = {py, px};
  assign m_axis_tuser = {col, hit};

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_miss_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("point not zero on a miss");

  a_overlap_is_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("overlap flag without hit");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(thr_q) || $past(cfg_we_i))
    else $error("threshold changed without a write");

endmodule

`default_nettype wire

// ===== sv/sid_front.sv =====
// Front stages of the segment intersection pipeline: differences, cross products,
// parallel decision and collinear result, and the dividend products.
// Depends on sid_pkg.
`default_nettype none

module sid_front import sid_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [8*COORD_BITS-1:0]       data_i,
  input  wire logic [ThrW-1:0]               thr_i,
  output logic                               valid_o,
  output logic [4*COORD_BITS+1+FRAC_BITS-1-COORD_BITS:0] ux_o,
  output logic [4*COORD_BITS+1+FRAC_BITS-1-COORD_BITS:0] uy_o,
  output logic [2*COORD_BITS:0]              ud_o,
  output logic [12*COORD_BITS+3:0]           side_o
);

  localparam int C   = COORD_BITS;
  localparam int DW1 = C + 1;
  localparam int PW  = 2*C + 2;
  localparam int MW  = 2*C + 1;
  localparam int QW  = 3*C + 1 + FRAC_BITS;
  localparam int XW  = C + MW;

  // stage 1
  logic signed [C-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  logic swap1, swap2;
  logic signed [C-1:0] lo1x, lo1y, hi1x, hi1y, lo2x, lo2y, hi2x, hi2y;

  assign ax = $signed(data_i[0*C +: C]);
  assign ay = $signed(data_i[1*C +: C]);
  assign bx = $signed(data_i[2*C +: C]);
  assign by = $signed(data_i[3*C +: C]);
  assign cx = $signed(data_i[4*C +: C]);
  assign cy = $signed(data_i[5*C +: C]);
  assign dx = $signed(data_i[6*C +: C]);
  assign dy = $signed(data_i[7*C +: C]);

  assign swap1 = lex_lt(WideW'(bx), WideW'(by), WideW'(ax), WideW'(ay));
  assign swap2 = lex_lt(WideW'(dx), WideW'(dy), WideW'(cx), WideW'(cy));
  assign lo1x = swap1 ? bx : ax;
  assign lo1y = swap1 ? by : ay;
  assign hi1x = swap1 ? ax : bx;
  assign hi1y = swap1 ? ay : by;
  assign lo2x = swap2 ? dx : cx;
  assign lo2y = swap2 ? dy : cy;
  assign hi2x = swap2 ? cx : dx;
  assign hi2y = swap2 ? cy : dy;

  logic                v1_q;
  logic signed [C:0]   ex1_q, ey1_q, fx1_q, fy1_q, gx1_q, gy1_q, hx1_q, hy1_q, kx1_q, ky1_q;
  logic signed [C-1:0] pt1_q [10];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex1_q <= DW1'(bx) - DW1'(ax);
      ey1_q <= DW1'(by) - DW1'(ay);
      fx1_q <= DW1'(dx) - DW1'(cx);
      fy1_q <= DW1'(dy) - DW1'(cy);
      gx1_q <= DW1'(cx) - DW1'(ax);
      gy1_q <= DW1'(cy) - DW1'(ay);
      hx1_q <= DW1'(hi1x) - DW1'(lo1x);
      hy1_q <= DW1'(hi1y) - DW1'(lo1y);
      kx1_q <= DW1'(lo2x) - DW1'(lo1x);
      ky1_q <= DW1'(lo2y) - DW1'(lo1y);
      pt1_q[0] <= ax;
      pt1_q[1] <= ay;
      pt1_q[2] <= lo1x;
      pt1_q[3] <= lo1y;
      pt1_q[4] <= hi1x;
      pt1_q[5] <= hi1y;
      pt1_q[6] <= lo2x;
      pt1_q[7] <= lo2y;
      pt1_q[8] <= hi2x;
      pt1_q[9] <= hi2y;
    end
  end

  // stage 2: products
  logic                v2_q;
  logic signed [PW-1:0] efa2_q, efb2_q, gfa2_q, gfb2_q, hka2_q, hkb2_q;
  logic signed [C:0]   ex2_q, ey2_q;
  logic signed [C-1:0] pt2_q [10];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      efa2_q <= PW'(ex1_q) * PW'(fy1_q);
      efb2_q <= PW'(ey1_q) * PW'(fx1_q);
      gfa2_q <= PW'(gx1_q) * PW'(fy1_q);
      gfb2_q <= PW'(gy1_q) * PW'(fx1_q);
      hka2_q <= PW'(hx1_q) * PW'(ky1_q);
      hkb2_q <= PW'(hy1_q) * PW'(kx1_q);
      ex2_q  <= ex1_q;
      ey2_q  <= ey1_q;
      pt2_q  <= pt1_q;
    end
  end

  // stage 3: cross products
  logic                 v3_q;
  logic signed [PW-1:0] det3_q, num3_q;
  logic                 pcz3_q;
  logic signed [C:0]    ex3_q, ey3_q;
  logic signed [C-1:0]  pt3_q [10];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det3_q <= efa2_q - efb2_q;
      num3_q <= gfa2_q - gfb2_q;
      pcz3_q <= (hka2_q == hkb2_q);
      ex3_q  <= ex2_q;
      ey3_q  <= ey2_q;
      pt3_q  <= pt2_q;
    end
  end

  // stage 4: magnitudes, parallel decision, collinear overlap
  logic [PW-1:0] det_abs, num_abs;
  logic [C:0]    ex_abs, ey_abs;
  logic          par_d, phit_d, take2;

  assign det_abs = det3_q[PW-1] ? PW'(-det3_q) : det3_q;
  assign num_abs = num3_q[PW-1] ? PW'(-num3_q) : num3_q;
  assign ex_abs  = ex3_q[C] ? DW1'(-ex3_q) : ex3_q;
  assign ey_abs  = ey3_q[C] ? DW1'(-ey3_q) : ey3_q;
  assign par_d   = (det3_q == '0) || (det_abs[MW-1:0] < MW'(thr_i));
  assign phit_d  = pcz3_q
      && !lex_lt(WideW'(pt3_q[4]), WideW'(pt3_q[5]), WideW'(pt3_q[6]), WideW'(pt3_q[7]))
      && !lex_lt(WideW'(pt3_q[8]), WideW'(pt3_q[9]), WideW'(pt3_q[2]), WideW'(pt3_q[3]));
  assign take2   = lex_lt(WideW'(pt3_q[2]), WideW'(pt3_q[3]), WideW'(pt3_q[6]),
                          WideW'(pt3_q[7]));

  logic                v4_q;
  logic [MW-1:0]       ud4_q, un4_q;
  logic [C-1:0]        uex4_q, uey4_q;
  logic                negx4_q, negy4_q, par4_q, phit4_q;
  logic signed [C-1:0] ppx4_q, ppy4_q;
  logic signed [C-1:0] pt4_q [10];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ud4_q   <= det_abs[MW-1:0];
      un4_q   <= num_abs[MW-1:0];
      uex4_q  <= ex_abs[C-1:0];
      uey4_q  <= ey_abs[C-1:0];
      negx4_q <= ex3_q[C] ^ num3_q[PW-1] ^ det3_q[PW-1];
      negy4_q <= ey3_q[C] ^ num3_q[PW-1] ^ det3_q[PW-1];
      par4_q  <= par_d;
      phit4_q <= phit_d;
      ppx4_q  <= take2 ? pt3_q[6] : pt3_q[2];
      ppy4_q  <= take2 ? pt3_q[7] : pt3_q[3];
      pt4_q   <= pt3_q;
    end
  end

  // stage 5: dividends
  logic [XW-1:0] prodx, prody;

  assign prodx = XW'(uex4_q) * XW'(un4_q);
  assign prody = XW'(uey4_q) * XW'(un4_q);

  logic v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_o   <= QW'({prodx, {FRAC_BITS{1'b0}}});
      uy_o   <= QW'({prody, {FRAC_BITS{1'b0}}});
      ud_o   <= ud4_q;
      side_o <= {negx4_q, negy4_q, par4_q, phit4_q, ppx4_q, ppy4_q,
                 pt4_q[0], pt4_q[1], pt4_q[2], pt4_q[3], pt4_q[4],
                 pt4_q[5], pt4_q[6], pt4_q[7], pt4_q[8], pt4_q[9]};
    end
  end

  assign valid_o = v5_q;

endmodule

`default_nettype wire

// ===== sv/sid_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two lanes on one divisor.
// Carries a side word alongside. Depends on sid_pkg.
`default_nettype none

module sid_div import sid_pkg::*; #(
  parameter int QW = 3*CoordBitsDef + 1 + FracBitsDef,
  parameter int DW = 2*CoordBitsDef + 1,
  parameter int SW = 12*CoordBitsDef + 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [QW-1:0] nx_i,
  input  wire logic [QW-1:0] ny_i,
  input  wire logic [DW-1:0] d_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [QW-1:0]      qx_o,
  output logic [QW-1:0]      qy_o,
  output logic [SW-1:0]      side_o
);

  logic          v_q  [QW];
  logic [DW-1:0] rx_q [QW];
  logic [DW-1:0] ry_q [QW];
  logic [QW-1:0] nx_q [QW];
  logic [QW-1:0] ny_q [QW];
  logic [DW-1:0] d_q  [QW];
  logic [SW-1:0] s_q  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic          pv;
    logic [DW-1:0] prx, pry, pd;
    logic [QW-1:0] pnx, pny;
    logic [SW-1:0] ps;
    logic [DW:0]   rsx, rsy;
    logic          gex, gey;
    logic [DW:0]   dfx, dfy;

    if (j == 0) begin : g_first
      assign pv  = valid_i;
      assign prx = '0;
      assign pry = '0;
      assign pnx = nx_i;
      assign pny = ny_i;
      assign pd  = d_i;
      assign ps  = side_i;
    end else begin : g_next
      assign pv  = v_q[j-1];
      assign prx = rx_q[j-1];
      assign pry = ry_q[j-1];
      assign pnx = nx_q[j-1];
      assign pny = ny_q[j-1];
      assign pd  = d_q[j-1];
      assign ps  = s_q[j-1];
    end

    assign rsx = {prx, pnx[QW-1]};
    assign rsy = {pry, pny[QW-1]};
    assign gex = rsx >= {1'b0, pd};
    assign gey = rsy >= {1'b0, pd};
    assign dfx = rsx - {1'b0, pd};
    assign dfy = rsy - {1'b0, pd};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[j] <= gex ? dfx[DW-1:0] : rsx[DW-1:0];
        ry_q[j] <= gey ? dfy[DW-1:0] : rsy[DW-1:0];
        nx_q[j] <= {pnx[QW-2:0], gex};
        ny_q[j] <= {pny[QW-2:0], gey};
        d_q[j]  <= pd;
        s_q[j]  <= ps;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign qx_o    = nx_q[QW-1];
  assign qy_o    = ny_q[QW-1];
  assign side_o  = s_q[QW-1];

endmodule

`default_nettype wire

// ===== sv/sid_back.sv =====
// Back stages of the segment intersection pipeline: signed offset with clamp,
// point sum, range tests, result select and saturation into the output register.
// Depends on sid_pkg.
`default_nettype none

module sid_back import sid_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          en_i,
  input  wire logic                                          valid_i,
  input  wire logic [4*COORD_BITS+1+FRAC_BITS-1-COORD_BITS:0] qx_i,
  input  wire logic [4*COORD_BITS+1+FRAC_BITS-1-COORD_BITS:0] qy_i,
  input  wire logic [12*COORD_BITS+3:0]                      side_i,
  output logic                                               valid_o,
  output logic                                               hit_o,
  output logic                                               col_o,
  output logic [PointW-1:0]                                  px_o,
  output logic [PointW-1:0]                                  py_o
);

  localparam int C  = COORD_BITS;
  localparam int QW = 3*C + 1 + FRAC_BITS;
  localparam int SW = 12*C + 4;
  localparam int EW = (QW > ClampExp + 1) ? QW : ClampExp + 1;
  localparam logic [EW-1:0] ClampE = EW'(1) << ClampExp;

  logic                negx, negy, par, phit;
  logic signed [C-1:0] cf [12];

  assign negx = side_i[SW-1];
  assign negy = side_i[SW-2];
  assign par  = side_i[SW-3];
  assign phit = side_i[SW-4];
  for (genvar k = 0; k < 12; k++) begin : g_unpack
    assign cf[k] = $signed(side_i[12*C-1-k*C -: C]);
  end

  logic [EW-1:0]            qxe, qye;
  logic [ClampExp:0]        magx, magy;
  logic signed [WideW-1:0]  offx, offy, sax, say;

  assign qxe  = EW'(qx_i);
  assign qye  = EW'(qy_i);
  assign magx = (qxe > ClampE) ? ClampE[ClampExp:0] : qxe[ClampExp:0];
  assign magy = (qye > ClampE) ? ClampE[ClampExp:0] : qye[ClampExp:0];
  assign offx = negx ? -$signed(WideW'(magx)) : $signed(WideW'(magx));
  assign offy = negy ? -$signed(WideW'(magy)) : $signed(WideW'(magy));
  assign sax  = WideW'(cf[2]) <<< FRAC_BITS;
  assign say  = WideW'(cf[3]) <<< FRAC_BITS;

  // stage 1: point
  logic                    v1_q, par1_q, phit1_q;
  logic signed [WideW-1:0] qx1_q, qy1_q;
  logic signed [C-1:0]     pt1_q [10];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qx1_q   <= sax + offx;
      qy1_q   <= say + offy;
      par1_q  <= par;
      phit1_q <= phit;
      pt1_q[0] <= cf[0];
      pt1_q[1] <= cf[1];
      for (int k = 2; k < 10; k++) begin
        pt1_q[k] <= cf[k+2];
      end
    end
  end

  // stage 2: range tests and result
  logic signed [WideW-1:0] sp [10];
  logic                    qhit, hit;
  logic signed [WideW-1:0] rx, ry;

  for (genvar k = 0; k < 10; k++) begin : g_scale
    assign sp[k] = WideW'(pt1_q[k]) <<< FRAC_BITS;
  end

  assign qhit = !lex_lt(qx1_q, qy1_q, sp[2], sp[3])
             && !lex_lt(sp[4], sp[5], qx1_q, qy1_q)
             && !lex_lt(qx1_q, qy1_q, sp[6], sp[7])
             && !lex_lt(sp[8], sp[9], qx1_q, qy1_q);
  assign hit  = par1_q ? phit1_q : qhit;
  assign rx   = par1_q ? sp[0] : qx1_q;
  assign ry   = par1_q ? sp[1] : qy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o <= hit;
      col_o <= par1_q & phit1_q;
      px_o  <= hit ? sat_pt(rx) : '0;
      py_o  <= hit ? sat_pt(ry) : '0;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_checker.sv =====
// Result checker for segment_intersection_2d: watches the request and result
// channels, predicts each result and compares it. Depends on sid_pkg.
`timescale 1ns / 100ps

module tb_checker import sid_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [127:0] s_tdata_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [63:0]  m_tdata_i,
  input  logic [1:0]   m_tuser_i,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  output int           errors_o,
  output int           pending_o
);

  typedef struct packed {
    logic              hit;
    logic              col;
    logic [31:0]       px;
    logic [31:0]       py;
  } isect_t;

  isect_t      expected_q[$];
  logic [15:0] threshold;

  assign pending_o = expected_q.size();

  function automatic logic lower(longint ux, longint uy, longint vx, longint vy);
    return (ux < vx) || ((ux == vx) && (uy < vy));
  endfunction

  function automatic longint clamp_sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // trunc(e*num*2^16/det), magnitude clamped to 2^62
  function automatic longint shift_of(longint e, longint num, longint det);
    logic signed [127:0] prod, q;
    logic signed [127:0] lim;
    prod = $signed(128'(e)) * $signed(128'(num)) * 128'sd65536;
    q = prod / $signed(128'(det));
    lim = 128'sd1 <<< 62;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return longint'(q);
  endfunction

  function automatic logic between(longint px, longint py, longint ax, longint ay,
                                   longint bx, longint by);
    longint t;
    if (lower(bx, by, ax, ay)) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    return (px == ax && py == ay) || (px == bx && py == by) ||
           (lower(ax, ay, px, py) && lower(px, py, bx, by));
  endfunction

  function automatic isect_t predict_pair(logic [127:0] d, logic [15:0] thr);
    longint ax, ay, bx, by, cx, cy, dx, dy, det, mag, num, qx, qy, t;
    isect_t r;
    ax = longint'($signed(d[15:0]));    ay = longint'($signed(d[31:16]));
    bx = longint'($signed(d[47:32]));   by = longint'($signed(d[63:48]));
    cx = longint'($signed(d[79:64]));   cy = longint'($signed(d[95:80]));
    dx = longint'($signed(d[111:96]));  dy = longint'($signed(d[127:112]));
    r = '0;
    det = (bx - ax) * (dy - cy) - (by - ay) * (dx - cx);
    mag = det < 0 ? -det : det;
    if (det == 0 || mag < longint'(thr)) begin
      if (lower(bx, by, ax, ay)) begin
        t = ax; ax = bx; bx = t; t = ay; ay = by; by = t;
      end
      if (lower(dx, dy, cx, cy)) begin
        t = cx; cx = dx; dx = t; t = cy; cy = dy; dy = t;
      end
      if ((bx - ax) * (cy - ay) - (by - ay) * (cx - ax) == 0 &&
          !lower(bx, by, cx, cy) && !lower(dx, dy, ax, ay)) begin
        r.hit = 1'b1;
        r.col = 1'b1;
        if (lower(ax, ay, cx, cy)) begin
          qx = cx; qy = cy;
        end else begin
          qx = ax; qy = ay;
        end
        r.px = 32'(qx * 65536);
        r.py = 32'(qy * 65536);
      end
    end else begin
      num = (cx - ax) * (dy - cy) - (cy - ay) * (dx - cx);
      qx = ax * 65536 + shift_of(bx - ax, num, det);
      qy = ay * 65536 + shift_of(by - ay, num, det);
      if (between(qx, qy, ax * 65536, ay * 65536, bx * 65536, by * 65536) &&
          between(qx, qy, cx * 65536, cy * 65536, dx * 65536, dy * 65536)) begin
        r.hit = 1'b1;
        r.px = 32'(clamp_sat(qx));
        r.py = 32'(clamp_sat(qy));
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    isect_t want;
    isect_t got;
    if (!rst_ni) begin
      threshold <= ThrReset;
      errors_o  <= 0;
      expected_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) expected_q.push_back(predict_pair(s_tdata_i, threshold));
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tuser_i[0], m_tuser_i[1], m_tdata_i[31:0], m_tdata_i[63:32]};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.hit != got.hit || want.col != got.col ||
              want.px != got.px || want.py != got.py) begin
            $display("%0t: mismatch expected hit=%b col=%b x=%h y=%h actual hit=%b col=%b x=%h y=%h",
                     $time, want.hit, want.col, want.px, want.py,
                     got.hit, got.col, got.px, got.py);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cfg_we_i) threshold <= cfg_wdata_i;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the segment_intersection_2d testbench: clock, reset, requests,
// threshold writes, receiver stalls and the verdict. Depends on sid_pkg, tb_checker.
`timescale 1ns / 100ps

module tb_top;
  import sid_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic [15:0]  cfg_wdata_i = '0;
  int           errors;
  int           pending;
  logic         quiet = 1'b0;
  logic         hold_go = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_off = 0;

  always #6 clk_i = ~clk_i;

  segment_intersection_2d dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_wdata_i
  );

  tb_checker chk (
    .clk_i, .rst_ni, .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser), .cfg_we_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done     <= 1'b1;
      hold_off      <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 16);
    end
  end

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  function automatic logic [127:0] make_pair(int mode);
    logic [127:0] d;
    logic [15:0]  ax, ay, dx, dy, kx, ky;
    for (int i = 0; i < 8; i++) d[i*16 +: 16] = rand_coord(mode);
    if ($urandom_range(3) == 0) begin
      // collinear: put c and d on line ab
      ax = d[15:0]; ay = d[31:16];
      dx = 16'($signed($urandom_range(6)) - 3);
      dy = 16'($signed($urandom_range(6)) - 3);
      kx = 16'($signed($urandom_range(8)) - 4);
      ky = 16'($signed($urandom_range(8)) - 4);
      d[47:32]  = ax + dx * 16'd4;  d[63:48]  = ay + dy * 16'd4;
      d[79:64]  = ax + dx * kx;     d[95:80]  = ay + dy * kx;
      d[111:96] = ax + dx * ky;     d[127:112] = ay + dy * ky;
    end
    return d;
  endfunction

  task automatic send(logic [127:0] d);
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!quiet && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  localparam logic [15:0] MaxC = 16'h7fff;
  localparam logic [15:0] MinC = 16'h8000;

  initial begin
    logic [15:0] thr_set[5];
    thr_set = '{16'd0, 16'hffff, 16'd1, 16'd50, 16'($urandom)};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // crossing, parallel, collinear overlap, touching, degenerate, extremes
    send({16'd10, 16'd0, 16'd0, 16'd10, 16'd10, 16'd10, 16'd0, 16'd0});
    send({16'd5, 16'd10, 16'd5, 16'd0, 16'd0, 16'd10, 16'd0, 16'd0});
    send({16'd0, 16'd8, 16'd0, 16'd2, 16'd0, 16'd5, 16'd0, 16'd0});
    send({16'd0, 16'd3, 16'd0, 16'd9, 16'd0, 16'd5, 16'd0, 16'd0});
    send({16'd3, 16'd3, 16'd3, 16'd3, 16'd6, 16'd6, 16'd0, 16'd0});
    send({16'd2, 16'd2, 16'd2, 16'd2, 16'd2, 16'd2, 16'd2, 16'd2});
    send({16'd1, 16'd7, 16'd2, 16'd7, 16'd1, 16'd3, 16'd0, 16'd3});
    send({MinC, MaxC, MaxC, MinC, MaxC, MaxC, MinC, MinC});
    send({MaxC, MaxC, MinC, MinC, MinC, MaxC, MaxC, MinC});
    send({MaxC, MinC, MaxC, MinC, MinC, MaxC, MinC, MaxC});
    send({16'd1, MaxC, 16'd0, MinC, MaxC, 16'd1, MinC, 16'd0});
    send({16'd3, 16'd1, 16'd0, 16'd0, 16'd1, 16'd3, 16'd0, 16'd0});
    send({16'd2, 16'd7, 16'd0, 16'd0, 16'd9, 16'd1, 16'd0, 16'd0});
    send('1);
    send('0);
    settle();
    for (int ph = 0; ph < 5; ph++) begin
      write_threshold(thr_set[ph]);
      for (int n = 0; n < 180; n++) begin
        if (ph == 1 && n == 20) hold_go <= 1'b1;
        quiet <= (ph == 2 && n >= 40 && n < 120);
        send(make_pair($urandom_range(2)));
      end
      settle();
    end
    if (errors == 0) begin
      $display("segment_intersection_2d test passed");
    end else begin
      $display("segment_intersection_2d test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("segment_intersection_2d test failed");
    $finish;
  end

endmodule
